/* hw/rtl/bia_pkg.sv */
package bia_pkg;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Largest index count that the configuration register can express.
    localparam int CFG_MAX = 2047;

    // Shift of the reciprocal used to split an index into word and bit.
    localparam int RECIP_SH = 18;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IS_FREE = 2'd3;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

/* hw/rtl/bitmap_index_allocator.sv */
// Lowest-free index allocator.
// A request enters on the s_ channel (s_kind, s_index): allocate, free or reset all.
// Each request produces exactly one transfer on the m_ channel carrying the
// allocated index, a status code and the number of indices taken afterwards.
// The free map lives in a memory of WORD_BITS-bit words; a word is
// read in ST_READ, then masked and priority-encoded in ST_CHECK by the one scan unit.
// An allocate passes through ST_DECODE, then ST_READ and ST_CHECK once for each
// map word scanned from the search hint (at most 16 with the default parameters),
// then ST_RESP. A free passes through ST_DECODE, ST_READ, ST_CHECK and ST_RESP;
// reset all, an out-of-range free, an allocate with the hint already at the
// limit and the unused kind go from ST_DECODE straight to ST_RESP.
// One request is worked on at a time: s_ready is high only while the scan unit
// is idle, which it becomes at the same clock edge that loads the result. A
// finished result sits in the output register while the next request is
// accepted; a stalled receiver holds the block in its final state. After
// aresetn every index is free, the hint and count are zero and the limit
// register holds 1024. Per-word valid bits make a reset-all request take
// effect at once, so no clearing pass is needed.
// The limit register sits at APB address 0 and may only be written while idle.
module bitmap_index_allocator #(
    parameter int MAX_INDICES = 1024,
    parameter int WORD_BITS   = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bia_pkg::KIND_W-1:0]    s_kind,
    input  logic [bia_pkg::IDX_W-1:0]     s_index,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bia_pkg::IDX_W-1:0]     m_given_index,
    output logic [bia_pkg::STAT_W-1:0]    m_status,
    output logic [bia_pkg::CNT_W-1:0]     m_allocated_count,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bia_pkg::PADDR_W-1:0]   paddr,
    input  logic [bia_pkg::PDATA_W-1:0]   pwdata,
    output logic [bia_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CNT_W   = bia_pkg::CNT_W;
    localparam int BASE_W  = CNT_W + 1;
    // Only indices below the largest reachable limit are ever touched.
    localparam int LIM_CAP = (MAX_INDICES < bia_pkg::CFG_MAX) ? MAX_INDICES
                                                               : bia_pkg::CFG_MAX;
    localparam int DEPTH   = (LIM_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int RECIP   = ((1 << bia_pkg::RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RC_W    = bia_pkg::RECIP_SH;
    localparam int PROD_W  = CNT_W + RC_W;
    localparam logic [CNT_W-1:0] LIM_CAP_V = CNT_W'(LIM_CAP);

    bia_pkg::state_t state_reg, state_next;

    logic [bia_pkg::KIND_W-1:0]  kind_reg;
    logic [bia_pkg::IDX_W-1:0]   idx_reg;
    logic [AW-1:0]               word_reg, word_next;
    logic [BASE_W-1:0]           base_reg, base_next;
    logic [CNT_W-1:0]            hint_reg, hint_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            limit_cfg_reg;
    logic [bia_pkg::IDX_W-1:0]   res_given_reg, res_given_next;
    logic [bia_pkg::STAT_W-1:0]  res_status_reg, res_status_next;

    logic                        m_valid_reg;
    logic [bia_pkg::IDX_W-1:0]   m_given_reg;
    logic [bia_pkg::STAT_W-1:0]  m_status_reg;
    logic [CNT_W-1:0]            m_count_reg;

    logic [WORD_BITS-1:0]        mem [DEPTH];
    logic [WORD_BITS-1:0]        mem_q_reg;
    logic                        vld_q_reg;
    logic [DEPTH-1:0]            valid_reg;

    logic                        mem_we;
    logic [WORD_BITS-1:0]        mem_wdata;
    logic                        valid_clr;

    logic [CNT_W-1:0]            lim;
    logic [CNT_W-1:0]            div_in;
    logic [PROD_W-1:0]           div_prod;
    logic [AW-1:0]               dec_word;
    logic [WORD_BITS-1:0]        word_data;
    logic [BASE_W-1:0]           lo_off;
    logic [BASE_W-1:0]           hi_off;
    logic [WORD_BITS-1:0]        scan_mask;
    logic [WORD_BITS-1:0]        cand;
    logic [BW-1:0]               pos;
    logic [BASE_W-1:0]           found_idx;
    logic [BASE_W-1:0]           word_end;
    logic [BW-1:0]               free_bit;
    logic                        out_free;
    logic                        s_accept;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? bia_pkg::PDATA_W'(limit_cfg_reg) : '0;

    // The limit is the only register, so every write lands in it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_cfg_reg <= bia_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            limit_cfg_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign lim = (limit_cfg_reg > LIM_CAP_V) ? LIM_CAP_V : limit_cfg_reg;

    // ---------------- scan datapath ----------------
    assign s_ready  = (state_reg == bia_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Word number of the hint or of the index to free, by reciprocal multiply.
    assign div_in   = (kind_reg == bia_pkg::KIND_FREE) ? CNT_W'(idx_reg) : hint_reg;
    assign div_prod = PROD_W'(div_in) * PROD_W'(RECIP);
    assign dec_word = AW'(div_prod >> bia_pkg::RECIP_SH);

    // A word that was never written since the last reset reads as all free.
    assign word_data = vld_q_reg ? mem_q_reg : '1;

    assign lo_off   = ({1'b0, hint_reg} > base_reg) ? ({1'b0, hint_reg} - base_reg) : '0;
    assign hi_off   = ({1'b0, lim} > base_reg) ? ({1'b0, lim} - base_reg) : '0;
    assign word_end = base_reg + BASE_W'(WORD_BITS);
    assign free_bit = BW'(BASE_W'(idx_reg) - base_reg);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            scan_mask[b] = (BASE_W'(b) >= lo_off) && (BASE_W'(b) < hi_off);
        end
    end

    assign cand = word_data & scan_mask;

    always_comb begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pos = BW'(b);
            end
        end
    end

    assign found_idx = base_reg + BASE_W'(pos);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        word_next       = word_reg;
        base_next       = base_reg;
        hint_next       = hint_reg;
        count_next      = count_reg;
        res_given_next  = res_given_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_wdata       = word_data;
        valid_clr       = 1'b0;

        case (state_reg)
            bia_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bia_pkg::ST_DECODE;
                end
            end
            bia_pkg::ST_DECODE: begin
                res_given_next  = '0;
                res_status_next = bia_pkg::STAT_OK;
                state_next      = bia_pkg::ST_RESP;
                case (kind_reg)
                    bia_pkg::KIND_ALLOC: begin
                        if (hint_reg >= lim) begin
                            res_status_next = bia_pkg::STAT_NO_FREE;
                        end else begin
                            word_next  = dec_word;
                            state_next = bia_pkg::ST_READ;
                        end
                    end
                    bia_pkg::KIND_FREE: begin
                        if (CNT_W'(idx_reg) >= lim) begin
                            res_status_next = bia_pkg::STAT_RANGE;
                        end else begin
                            word_next  = dec_word;
                            state_next = bia_pkg::ST_READ;
                        end
                    end
                    bia_pkg::KIND_RESET: begin
                        hint_next  = '0;
                        count_next = '0;
                        valid_clr  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            bia_pkg::ST_READ: begin
                base_next  = BASE_W'(word_reg) * BASE_W'(WORD_BITS);
                state_next = bia_pkg::ST_CHECK;
            end
            bia_pkg::ST_CHECK: begin
                state_next = bia_pkg::ST_RESP;
                if (kind_reg == bia_pkg::KIND_FREE) begin
                    if (word_data[free_bit]) begin
                        res_status_next = bia_pkg::STAT_IS_FREE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = word_data | (WORD_BITS'(1) << free_bit);
                        if (hint_reg > CNT_W'(idx_reg)) begin
                            hint_next = CNT_W'(idx_reg);
                        end
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end else if (cand != '0) begin
                    mem_we         = 1'b1;
                    mem_wdata      = word_data & ~(WORD_BITS'(1) << pos);
                    res_given_next = found_idx[bia_pkg::IDX_W-1:0];
                    hint_next      = CNT_W'(found_idx + BASE_W'(1));
                    count_next     = count_reg + CNT_W'(1);
                end else if (word_end >= {1'b0, lim}) begin
                    res_status_next = bia_pkg::STAT_NO_FREE;
                    if (hint_reg < lim) begin
                        hint_next = lim;
                    end
                end else begin
                    word_next  = word_reg + AW'(1);
                    state_next = bia_pkg::ST_READ;
                end
            end
            bia_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = bia_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bia_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bia_pkg::ST_IDLE;
            hint_reg    <= '0;
            count_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            count_reg <= count_next;
            if (valid_clr) begin
                valid_reg <= '0;
            end else if (mem_we) begin
                valid_reg[word_reg] <= 1'b1;
            end
            if (state_reg == bia_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= s_kind;
            idx_reg  <= s_index;
        end
        word_reg       <= word_next;
        base_reg       <= base_next;
        res_given_reg  <= res_given_next;
        res_status_reg <= res_status_next;
        if (state_reg == bia_pkg::ST_RESP && out_free) begin
            m_given_reg  <= res_given_reg;
            m_status_reg <= res_status_reg;
            m_count_reg  <= count_reg;
        end
    end

    // Free map storage: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[word_reg] <= mem_wdata;
        end
        if (state_reg == bia_pkg::ST_READ) begin
            mem_q_reg <= mem[word_reg];
            vld_q_reg <= valid_reg[word_reg];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_given_index     = m_given_reg;
    assign m_status          = m_status_reg;
    assign m_allocated_count = m_count_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LIM_CAP_V)
        else $error("allocated count exceeds the number of reachable indices");

    a_hint_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= LIM_CAP_V)
        else $error("search hint beyond the reachable index range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input accepted again before the request finished");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bia_pkg::ST_RESP && out_free) |=> m_valid)
        else $error("finished request did not reach the output register");

endmodule
